// File: sv/cbct_pkg.sv
`default_nettype none
// ============================================================================
// cbct_pkg
// Shared types and codes for the circle/box collision test pipeline.
// ============================================================================
package cbct_pkg;

    // Pair kind, carried on the input tuser
    localparam int KIND_BITS = 2;
    typedef logic [KIND_BITS-1:0] t_kind;
    localparam t_kind KIND_RECT   = 2'd0;
    localparam t_kind KIND_CIRCLE = 2'd1;
    localparam t_kind KIND_OTHER  = 2'd2;

    // Side of the rectangle met by a circle
    localparam int SIDE_BITS = 3;
    typedef enum logic [SIDE_BITS-1:0] {
        SIDE_NONE   = 3'd0,
        SIDE_TOP    = 3'd1,
        SIDE_BOTTOM = 3'd2,
        SIDE_LEFT   = 3'd3,
        SIDE_RIGHT  = 3'd4,
        SIDE_CORNER = 3'd5
    } t_side;

endpackage
`default_nettype wire

// File: sv/cbct_setup.sv
`default_nettype none
// ============================================================================
// cbct_setup
// First stage: form the circle centre in the 5-fraction-bit working format
// and the far edges of both shapes.
// ============================================================================
module cbct_setup #(
    parameter int CB = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire cbct_pkg::t_kind      i_kind,
    input  wire logic [CB-1:0]        i_a_x,
    input  wire logic [CB-1:0]        i_a_y,
    input  wire logic [CB-2:0]        i_a_w,
    input  wire logic [CB-2:0]        i_a_h,
    input  wire logic [CB-1:0]        i_b_x,
    input  wire logic [CB-1:0]        i_b_y,
    input  wire logic [CB-2:0]        i_b_w,
    input  wire logic [CB-2:0]        i_b_h,
    output logic                      o_rect,
    output logic                      o_circ,
    output logic                      o_area,
    output logic signed [CB:0]        o_ax,
    output logic signed [CB:0]        o_ay,
    output logic signed [CB:0]        o_bx,
    output logic signed [CB:0]        o_by,
    output logic signed [CB:0]        o_a_r,
    output logic signed [CB:0]        o_a_b,
    output logic signed [CB:0]        o_b_r,
    output logic signed [CB:0]        o_b_b,
    output logic signed [CB+1:0]      o_cx,
    output logic signed [CB+1:0]      o_cy,
    output logic [CB-2:0]             o_r
);
    import cbct_pkg::*;

    logic [CB:0]   n_a_r, n_a_b, n_b_r, n_b_b;
    logic [CB+1:0] n_cx, n_cy;

    // Far edges at 4 fraction bits, circle centre at 5 fraction bits
    always_comb begin
        n_a_r = {i_a_x[CB-1], i_a_x} + {2'b00, i_a_w};
        n_a_b = {i_a_y[CB-1], i_a_y} + {2'b00, i_a_h};
        n_b_r = {i_b_x[CB-1], i_b_x} + {2'b00, i_b_w};
        n_b_b = {i_b_y[CB-1], i_b_y} + {2'b00, i_b_h};
        n_cx  = {i_a_x[CB-1], i_a_x, 1'b0} + {3'b000, i_a_w};
        n_cy  = {i_a_y[CB-1], i_a_y, 1'b0} + {3'b000, i_a_w};
    end

    // Register the stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rect <= (i_kind == KIND_RECT);
            o_circ <= (i_kind == KIND_CIRCLE);
            o_area <= (i_a_w != '0) && (i_a_h != '0) && (i_b_w != '0) && (i_b_h != '0);
            o_ax   <= $signed({i_a_x[CB-1], i_a_x});
            o_ay   <= $signed({i_a_y[CB-1], i_a_y});
            o_bx   <= $signed({i_b_x[CB-1], i_b_x});
            o_by   <= $signed({i_b_y[CB-1], i_b_y});
            o_a_r  <= $signed(n_a_r);
            o_a_b  <= $signed(n_a_b);
            o_b_r  <= $signed(n_b_r);
            o_b_b  <= $signed(n_b_b);
            o_cx   <= $signed(n_cx);
            o_cy   <= $signed(n_cy);
            o_r    <= i_a_w;
        end
    end

endmodule
`default_nettype wire

// File: sv/cbct_clamp.sv
`default_nettype none
// ============================================================================
// cbct_clamp
// Second stage: decide the rectangle pair overlap and clamp the circle
// centre onto the rectangle to find the closest point.
// ============================================================================
module cbct_clamp #(
    parameter int CB = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic                 i_rect,
    input  wire logic                 i_circ,
    input  wire logic                 i_area,
    input  wire logic signed [CB:0]   i_ax,
    input  wire logic signed [CB:0]   i_ay,
    input  wire logic signed [CB:0]   i_bx,
    input  wire logic signed [CB:0]   i_by,
    input  wire logic signed [CB:0]   i_a_r,
    input  wire logic signed [CB:0]   i_a_b,
    input  wire logic signed [CB:0]   i_b_r,
    input  wire logic signed [CB:0]   i_b_b,
    input  wire logic signed [CB+1:0] i_cx,
    input  wire logic signed [CB+1:0] i_cy,
    input  wire logic [CB-2:0]        i_r,
    output logic                      o_rect_hit,
    output logic                      o_circ,
    output logic signed [CB+1:0]      o_cx,
    output logic signed [CB+1:0]      o_cy,
    output logic signed [CB+1:0]      o_px,
    output logic signed [CB+1:0]      o_py,
    output logic signed [CB+1:0]      o_l,
    output logic signed [CB+1:0]      o_rt,
    output logic signed [CB+1:0]      o_t,
    output logic signed [CB+1:0]      o_bt,
    output logic [CB-2:0]             o_r
);
    import cbct_pkg::*;

    logic signed [CB+1:0] n_l, n_rt, n_t, n_bt, n_px, n_py;
    logic                 n_ox, n_oy;

    always_comb begin
        // Rectangle edges in the working format
        n_l  = $signed({i_bx, 1'b0});
        n_rt = $signed({i_b_r, 1'b0});
        n_t  = $signed({i_by, 1'b0});
        n_bt = $signed({i_b_b, 1'b0});
        // Strict overlap on each axis
        n_ox = (i_ax < i_b_r) && (i_bx < i_a_r);
        n_oy = (i_ay < i_b_b) && (i_by < i_a_b);
        // Clamp the centre onto the rectangle
        n_px = (i_cx < n_l) ? n_l : ((i_cx > n_rt) ? n_rt : i_cx);
        n_py = (i_cy < n_t) ? n_t : ((i_cy > n_bt) ? n_bt : i_cy);
    end

    // Register the stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rect_hit <= i_rect && i_area && n_ox && n_oy;
            o_circ     <= i_circ;
            o_cx       <= i_cx;
            o_cy       <= i_cy;
            o_px       <= n_px;
            o_py       <= n_py;
            o_l        <= n_l;
            o_rt       <= n_rt;
            o_t        <= n_t;
            o_bt       <= n_bt;
            o_r        <= i_r;
        end
    end

endmodule
`default_nettype wire

// File: sv/cbct_dist.sv
`default_nettype none
// ============================================================================
// cbct_dist
// Third stage: offsets from the centre to the closest point, and distances
// from that point to each rectangle edge.
// ============================================================================
module cbct_dist #(
    parameter int CB = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic                 i_rect_hit,
    input  wire logic                 i_circ,
    input  wire logic signed [CB+1:0] i_cx,
    input  wire logic signed [CB+1:0] i_cy,
    input  wire logic signed [CB+1:0] i_px,
    input  wire logic signed [CB+1:0] i_py,
    input  wire logic signed [CB+1:0] i_l,
    input  wire logic signed [CB+1:0] i_rt,
    input  wire logic signed [CB+1:0] i_t,
    input  wire logic signed [CB+1:0] i_bt,
    input  wire logic [CB-2:0]        i_r,
    output logic                      o_rect_hit,
    output logic                      o_circ,
    output logic [CB+1:0]             o_dx,
    output logic [CB+1:0]             o_dy,
    output logic [CB-1:0]             o_dl,
    output logic [CB-1:0]             o_dr,
    output logic [CB-1:0]             o_dt,
    output logic [CB-1:0]             o_db,
    output logic [CB+1:0]             o_px,
    output logic [CB+1:0]             o_py,
    output logic [CB-2:0]             o_r
);
    import cbct_pkg::*;

    logic [CB+2:0] n_diff_x, n_diff_y, n_neg_x, n_neg_y;
    logic [CB+1:0] n_dl, n_dr, n_dt, n_db;

    always_comb begin
        // Absolute offsets, one bit wider for the difference
        n_diff_x = {i_cx[CB+1], i_cx} - {i_px[CB+1], i_px};
        n_diff_y = {i_cy[CB+1], i_cy} - {i_py[CB+1], i_py};
        n_neg_x  = -n_diff_x;
        n_neg_y  = -n_diff_y;
        // Edge distances are at most twice the rectangle size
        n_dl = i_px - i_l;
        n_dr = i_rt - i_px;
        n_dt = i_py - i_t;
        n_db = i_bt - i_py;
    end

    // Register the stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rect_hit <= i_rect_hit;
            o_circ     <= i_circ;
            o_dx       <= n_diff_x[CB+2] ? n_neg_x[CB+1:0] : n_diff_x[CB+1:0];
            o_dy       <= n_diff_y[CB+2] ? n_neg_y[CB+1:0] : n_diff_y[CB+1:0];
            o_dl       <= n_dl[CB-1:0];
            o_dr       <= n_dr[CB-1:0];
            o_dt       <= n_dt[CB-1:0];
            o_db       <= n_db[CB-1:0];
            o_px       <= i_px;
            o_py       <= i_py;
            o_r        <= i_r;
        end
    end

endmodule
`default_nettype wire

// File: sv/cbct_square.sv
`default_nettype none
// ============================================================================
// cbct_square
// Fourth stage: bound the offsets by the radius, square the offsets and the
// radius, and pick the nearer edge on each axis.
// ============================================================================
module cbct_square #(
    parameter int CB = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire logic            i_rect_hit,
    input  wire logic            i_circ,
    input  wire logic [CB+1:0]   i_dx,
    input  wire logic [CB+1:0]   i_dy,
    input  wire logic [CB-1:0]   i_dl,
    input  wire logic [CB-1:0]   i_dr,
    input  wire logic [CB-1:0]   i_dt,
    input  wire logic [CB-1:0]   i_db,
    input  wire logic [CB+1:0]   i_px,
    input  wire logic [CB+1:0]   i_py,
    input  wire logic [CB-2:0]   i_r,
    output logic                 o_rect_hit,
    output logic                 o_near,
    output logic [2*CB-3:0]      o_sq_x,
    output logic [2*CB-3:0]      o_sq_y,
    output logic [2*CB-3:0]      o_sq_r,
    output logic [CB-1:0]        o_mv,
    output logic [CB-1:0]        o_mh,
    output logic                 o_top_lt,
    output logic                 o_left_lt,
    output logic [CB+1:0]        o_px,
    output logic [CB+1:0]        o_py
);
    import cbct_pkg::*;

    logic [CB-2:0]   n_dx_lo, n_dy_lo;
    logic [2*CB-3:0] n_sq_x, n_sq_y, n_sq_r;
    logic            n_near;

    always_comb begin
        // Offsets inside the radius fit in the radius width
        n_near  = i_circ && (i_dx <= {3'b000, i_r}) && (i_dy <= {3'b000, i_r});
        n_dx_lo = i_dx[CB-2:0];
        n_dy_lo = i_dy[CB-2:0];
        n_sq_x  = n_dx_lo * n_dx_lo;
        n_sq_y  = n_dy_lo * n_dy_lo;
        n_sq_r  = i_r * i_r;
    end

    // Register the stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rect_hit <= i_rect_hit;
            o_near     <= n_near;
            o_sq_x     <= n_sq_x;
            o_sq_y     <= n_sq_y;
            o_sq_r     <= n_sq_r;
            o_mv       <= (i_dt < i_db) ? i_dt : i_db;
            o_mh       <= (i_dl < i_dr) ? i_dl : i_dr;
            o_top_lt   <= (i_dt < i_db);
            o_left_lt  <= (i_dl < i_dr);
            o_px       <= i_px;
            o_py       <= i_py;
        end
    end

endmodule
`default_nettype wire

// File: sv/circle_box_collision_test_unit.sv
`default_nettype none
// ============================================================================
// circle_box_collision_test_unit
// Five-stage pipelined collision test for rectangle pairs and circle against
// rectangle, with closest point and side of contact.
// ============================================================================
// Usage:
//   Input stream s_axis_*: one shape pair per transfer, kind on tuser and the
//   eight coordinates and sizes packed in tdata.
//   Output stream m_axis_*: one result per transfer, hit on tuser, side and
//   contact point in tdata (5 fraction bits).
//   Throughput: one pair per cycle while no stall backs up to s_axis_tready;
//   the stages are setup, clamp, distance, square and decide, each one
//   register deep.
//   Each stage holds its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up and a stall at m_axis_tready
//   backs up stage by stage; a new pair is taken while a result waits as long
//   as some stage is empty. Nothing is dropped or repeated.
//   Reset clears all valid bits; the block keeps no other state.
// ============================================================================
module circle_box_collision_test_unit #(
    parameter  int COORD_BITS = 16,
    localparam int IN_BITS    = 8 * COORD_BITS - 4,
    localparam int IN_TDATA   = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = 2 * COORD_BITS + 7,
    localparam int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h (from bit 0 up), zero padded
    input  wire logic [IN_TDATA-1:0]  s_axis_tdata,
    // kind
    input  wire cbct_pkg::t_kind      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // hit_side, contact_x, contact_y (from bit 0 up), zero padded
    output logic [OUT_TDATA-1:0]      m_axis_tdata,
    // hit
    output logic                      m_axis_tuser
);
    import cbct_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int NSTG = 5;

    // Stage handshake
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   n_rdy;

    // Stage 1 outputs
    logic                 s1_rect, s1_circ, s1_area;
    logic signed [CB:0]   s1_ax, s1_ay, s1_bx, s1_by, s1_a_r, s1_a_b, s1_b_r, s1_b_b;
    logic signed [CB+1:0] s1_cx, s1_cy;
    logic [CB-2:0]        s1_r;
    // Stage 2 outputs
    logic                 s2_rect_hit, s2_circ;
    logic signed [CB+1:0] s2_cx, s2_cy, s2_px, s2_py, s2_l, s2_rt, s2_t, s2_bt;
    logic [CB-2:0]        s2_r;
    // Stage 3 outputs
    logic                 s3_rect_hit, s3_circ;
    logic [CB+1:0]        s3_dx, s3_dy, s3_px, s3_py;
    logic [CB-1:0]        s3_dl, s3_dr, s3_dt, s3_db;
    logic [CB-2:0]        s3_r;
    // Stage 4 outputs
    logic                 s4_rect_hit, s4_near, s4_top_lt, s4_left_lt;
    logic [2*CB-3:0]      s4_sq_x, s4_sq_y, s4_sq_r;
    logic [CB-1:0]        s4_mv, s4_mh;
    logic [CB+1:0]        s4_px, s4_py;
    // Result stage
    logic                 r_hit;
    t_side                r_side;
    logic [CB+1:0]        r_cx, r_cy;
    logic [2*CB-2:0]      n_sum;
    logic                 n_circ_hit;
    t_side                n_side;

    // Ready chain: a stage loads when empty or when its successor moves
    always_comb begin
        n_rdy[NSTG] = m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            n_rdy[k] = !r_vld[k] || n_rdy[k+1];
        end
    end

    assign s_axis_tready = n_rdy[0];

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (n_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    cbct_setup #(.CB(CB)) u_setup (
        .i_clk  (i_clk),
        .i_en   (n_rdy[0]),
        .i_kind (s_axis_tuser),
        .i_a_x  (s_axis_tdata[CB-1:0]),
        .i_a_y  (s_axis_tdata[2*CB-1:CB]),
        .i_a_w  (s_axis_tdata[3*CB-2:2*CB]),
        .i_a_h  (s_axis_tdata[4*CB-3:3*CB-1]),
        .i_b_x  (s_axis_tdata[5*CB-3:4*CB-2]),
        .i_b_y  (s_axis_tdata[6*CB-3:5*CB-2]),
        .i_b_w  (s_axis_tdata[7*CB-4:6*CB-2]),
        .i_b_h  (s_axis_tdata[8*CB-5:7*CB-3]),
        .o_rect (s1_rect),
        .o_circ (s1_circ),
        .o_area (s1_area),
        .o_ax   (s1_ax),
        .o_ay   (s1_ay),
        .o_bx   (s1_bx),
        .o_by   (s1_by),
        .o_a_r  (s1_a_r),
        .o_a_b  (s1_a_b),
        .o_b_r  (s1_b_r),
        .o_b_b  (s1_b_b),
        .o_cx   (s1_cx),
        .o_cy   (s1_cy),
        .o_r    (s1_r)
    );

    cbct_clamp #(.CB(CB)) u_clamp (
        .i_clk      (i_clk),
        .i_en       (n_rdy[1]),
        .i_rect     (s1_rect),
        .i_circ     (s1_circ),
        .i_area     (s1_area),
        .i_ax       (s1_ax),
        .i_ay       (s1_ay),
        .i_bx       (s1_bx),
        .i_by       (s1_by),
        .i_a_r      (s1_a_r),
        .i_a_b      (s1_a_b),
        .i_b_r      (s1_b_r),
        .i_b_b      (s1_b_b),
        .i_cx       (s1_cx),
        .i_cy       (s1_cy),
        .i_r        (s1_r),
        .o_rect_hit (s2_rect_hit),
        .o_circ     (s2_circ),
        .o_cx       (s2_cx),
        .o_cy       (s2_cy),
        .o_px       (s2_px),
        .o_py       (s2_py),
        .o_l        (s2_l),
        .o_rt       (s2_rt),
        .o_t        (s2_t),
        .o_bt       (s2_bt),
        .o_r        (s2_r)
    );

    cbct_dist #(.CB(CB)) u_dist (
        .i_clk      (i_clk),
        .i_en       (n_rdy[2]),
        .i_rect_hit (s2_rect_hit),
        .i_circ     (s2_circ),
        .i_cx       (s2_cx),
        .i_cy       (s2_cy),
        .i_px       (s2_px),
        .i_py       (s2_py),
        .i_l        (s2_l),
        .i_rt       (s2_rt),
        .i_t        (s2_t),
        .i_bt       (s2_bt),
        .i_r        (s2_r),
        .o_rect_hit (s3_rect_hit),
        .o_circ     (s3_circ),
        .o_dx       (s3_dx),
        .o_dy       (s3_dy),
        .o_dl       (s3_dl),
        .o_dr       (s3_dr),
        .o_dt       (s3_dt),
        .o_db       (s3_db),
        .o_px       (s3_px),
        .o_py       (s3_py),
        .o_r        (s3_r)
    );

    cbct_square #(.CB(CB)) u_square (
        .i_clk      (i_clk),
        .i_en       (n_rdy[3]),
        .i_rect_hit (s3_rect_hit),
        .i_circ     (s3_circ),
        .i_dx       (s3_dx),
        .i_dy       (s3_dy),
        .i_dl       (s3_dl),
        .i_dr       (s3_dr),
        .i_dt       (s3_dt),
        .i_db       (s3_db),
        .i_px       (s3_px),
        .i_py       (s3_py),
        .i_r        (s3_r),
        .o_rect_hit (s4_rect_hit),
        .o_near     (s4_near),
        .o_sq_x     (s4_sq_x),
        .o_sq_y     (s4_sq_y),
        .o_sq_r     (s4_sq_r),
        .o_mv       (s4_mv),
        .o_mh       (s4_mh),
        .o_top_lt   (s4_top_lt),
        .o_left_lt  (s4_left_lt),
        .o_px       (s4_px),
        .o_py       (s4_py)
    );

    // Decide the circle hit and the side met
    always_comb begin
        n_sum      = {1'b0, s4_sq_x} + {1'b0, s4_sq_y};
        n_circ_hit = s4_near && (n_sum <= {1'b0, s4_sq_r});
        if (!n_circ_hit) begin
            n_side = SIDE_NONE;
        end else if (s4_mv == s4_mh) begin
            n_side = SIDE_CORNER;
        end else if (s4_mv < s4_mh) begin
            n_side = s4_top_lt ? SIDE_TOP : SIDE_BOTTOM;
        end else begin
            n_side = s4_left_lt ? SIDE_LEFT : SIDE_RIGHT;
        end
    end

    // Hold the result until the transfer completes
    always_ff @(posedge i_clk) begin
        if (n_rdy[4]) begin
            r_hit  <= s4_rect_hit || n_circ_hit;
            r_side <= n_side;
            r_cx   <= n_circ_hit ? s4_px : '0;
            r_cy   <= n_circ_hit ? s4_py : '0;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tuser  = r_hit;
    assign m_axis_tdata  = OUT_TDATA'({r_cy, r_cx, r_side});

endmodule
`default_nettype wire

// File: test/circle_box_collision_test_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// circle_box_collision_test_unit_tb
// Self-checking bench for the circle/box collision test pipeline. A short
// table of hand-picked shape pairs comes first: touching and overlapping
// boxes, circles meeting each side and a corner, zero sizes and the
// coordinate extremes. Random pairs follow, most of them placed near each
// other so that hits are common. Every result is compared field by field
// with an in-bench prediction or a typed-in expectation. Both stream sides
// stall at random in two phases, then a third phase runs with no stalls.
// ============================================================================
module circle_box_collision_test_unit_tb;

    import cbct_pkg::*;

    localparam int CB        = 16;
    localparam int SB        = CB - 1;
    localparam int OB        = CB + 2;
    localparam int IN_TDATA  = ((8 * CB - 4 + 7) / 8) * 8;
    localparam int OUT_TDATA = ((2 * CB + 7 + 7) / 8) * 8;
    localparam int RAND_PAIRS = 1830;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;
    // Spare kind code, never hits
    localparam t_kind KIND_UNUSED = 2'd3;

    // Input tdata layout, highest field first
    typedef struct packed {
        logic [IN_TDATA-8*CB+3:0] pad;
        logic [SB-1:0]            b_h;
        logic [SB-1:0]            b_w;
        logic signed [CB-1:0]     b_y;
        logic signed [CB-1:0]     b_x;
        logic [SB-1:0]            a_h;
        logic [SB-1:0]            a_w;
        logic signed [CB-1:0]     a_y;
        logic signed [CB-1:0]     a_x;
    } t_pair;

    typedef struct packed {
        logic          hit;
        t_side         side;
        logic [OB-1:0] cx;
        logic [OB-1:0] cy;
    } t_contact;

    // One row of the directed table; lit marks a typed-in expectation
    typedef struct packed {
        t_kind kind;
        int    ax, ay, aw, ah, bx, by, bw, bh;
        bit    lit;
        bit    hit;
    } t_shape_row;

    localparam int ROWS = 23;
    t_shape_row shape_table [ROWS] = '{
        // box pairs: overlap, shared edge, shared corner, zero width
        '{KIND_RECT,    0, 0, 16, 16, 8, 8, 16, 16,                 1'b1, 1'b1},
        '{KIND_RECT,    0, 0, 16, 16, 16, 0, 16, 16,                1'b1, 1'b0},
        '{KIND_RECT,    0, 0, 16, 16, 16, 16, 16, 16,               1'b1, 1'b0},
        '{KIND_RECT,    8, 8, 0, 16, 0, 0, 32, 32,                  1'b1, 1'b0},
        // box pairs at the coordinate extremes
        '{KIND_RECT,    -32768, -32768, 32767, 32767,
                        32767, 32767, 32767, 32767,                 1'b1, 1'b0},
        '{KIND_RECT,    -32768, -32768, 32767, 32767,
                        -100, -100, 50, 50,                         1'b1, 1'b1},
        // other pairs never hit
        '{KIND_OTHER,   -1, -1, 32767, 32767, -1, -1, 32767, 32767, 1'b1, 1'b0},
        '{KIND_UNUSED,  0, 0, 64, 64, 0, 0, 64, 64,                 1'b1, 1'b0},
        // zero diameter: centre inside, centre outside
        '{KIND_CIRCLE,  8, 8, 0, 0, 0, 0, 16, 16,                   1'b0, 1'b0},
        '{KIND_CIRCLE,  40, 8, 0, 0, 0, 0, 16, 16,                  1'b0, 1'b0},
        // just touching the left edge, then one step short
        '{KIND_CIRCLE,  0, 0, 32, 0, 32, 0, 32, 32,                 1'b0, 1'b0},
        '{KIND_CIRCLE,  -1, 0, 32, 0, 32, 0, 32, 32,                1'b0, 1'b0},
        // exact reach to a corner, then one step short
        '{KIND_CIRCLE,  0, 0, 10, 0, 8, 9, 16, 16,                  1'b0, 1'b0},
        '{KIND_CIRCLE,  0, 0, 10, 0, 8, 10, 16, 16,                 1'b0, 1'b0},
        // top, bottom and right sides
        '{KIND_CIRCLE,  8, -10, 16, 0, 0, 0, 64, 64,                1'b0, 1'b0},
        '{KIND_CIRCLE,  8, 62, 16, 0, 0, 0, 64, 64,                 1'b0, 1'b0},
        '{KIND_CIRCLE,  62, 20, 16, 0, 0, 0, 64, 64,                1'b0, 1'b0},
        // centre in the middle of a square: all distances tie
        '{KIND_CIRCLE,  0, 0, 64, 0, 0, 0, 64, 64,                  1'b0, 1'b0},
        // left/right tie and top/bottom tie
        '{KIND_CIRCLE,  8, 32, 0, 0, 0, 0, 16, 64,                  1'b0, 1'b0},
        '{KIND_CIRCLE,  32, 8, 0, 0, 0, 0, 64, 16,                  1'b0, 1'b0},
        // circles at the coordinate extremes
        '{KIND_CIRCLE,  -32768, -32768, 32767, 32767,
                        32767, 32767, 32767, 32767,                 1'b0, 1'b0},
        '{KIND_CIRCLE,  32767, 32767, 32767, 32767,
                        32767, 32767, 32767, 32767,                 1'b0, 1'b0},
        '{KIND_CIRCLE,  -32768, -32768, 0, 0, -32768, -32768, 0, 0, 1'b0, 1'b0}
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    t_pair                s_axis_tdata  = '0;     // a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h
    t_kind                s_axis_tuser  = KIND_RECT; // kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_TDATA-1:0] m_axis_tdata;           // hit_side, contact_x, contact_y
    logic                 m_axis_tuser;           // hit

    t_contact expected_contacts [$];
    int       fail_count   = 0;
    int       quiet_cycles = 0;
    int       src_idle_pct = 7;
    int       snk_idle_pct = 70;

    circle_box_collision_test_unit #(
        .COORD_BITS (CB)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Work out hit, side and closest point for one shape pair
    function automatic t_contact predict_contact(t_kind kind, t_pair p);
        longint   ax, ay, aw, ah, bx, by, bw, bh;
        longint   cx, cy, l, rt, t, bt, px, py, dx, dy;
        longint   dl, dr, dt, db, mv, mh;
        t_contact c;
        c  = '0;
        ax = longint'(p.a_x);
        ay = longint'(p.a_y);
        aw = longint'({1'b0, p.a_w});
        ah = longint'({1'b0, p.a_h});
        bx = longint'(p.b_x);
        by = longint'(p.b_y);
        bw = longint'({1'b0, p.b_w});
        bh = longint'({1'b0, p.b_h});
        if (kind == KIND_RECT) begin
            c.hit = ((ax > bx ? ax : bx) < (ax + aw < bx + bw ? ax + aw : bx + bw)) &&
                    ((ay > by ? ay : by) < (ay + ah < by + bh ? ay + ah : by + bh));
        end else if (kind == KIND_CIRCLE) begin
            // Work at 5 fraction bits: radius is aw, centre is 2*a + aw
            cx = 2 * ax + aw;
            cy = 2 * ay + aw;
            l  = 2 * bx;
            rt = 2 * (bx + bw);
            t  = 2 * by;
            bt = 2 * (by + bh);
            px = clamp_to(cx, l, rt);
            py = clamp_to(cy, t, bt);
            dx = (cx >= px) ? cx - px : px - cx;
            dy = (cy >= py) ? cy - py : py - cy;
            if (dx <= aw && dy <= aw && dx * dx + dy * dy <= aw * aw) begin
                dl = px - l;
                dr = rt - px;
                dt = py - t;
                db = bt - py;
                mv = (dt < db) ? dt : db;
                mh = (dl < dr) ? dl : dr;
                c.hit = 1'b1;
                if (mv == mh) begin
                    c.side = SIDE_CORNER;
                end else if (mv < mh) begin
                    if (dt < db) c.side = SIDE_TOP;
                    else         c.side = SIDE_BOTTOM;
                end else begin
                    if (dl < dr) c.side = SIDE_LEFT;
                    else         c.side = SIDE_RIGHT;
                end
                c.cx = px[OB-1:0];
                c.cy = py[OB-1:0];
            end
        end
        return c;
    endfunction

    // Offer one pair after a random gap; record its expectation on transfer
    task automatic offer_pair(input t_kind kind, input t_pair p, input bit lit,
                              input t_contact typed);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tuser  <= kind;
        while (!taken) begin
            @(posedge i_clk);
            taken = s_axis_tready;
        end
        expected_contacts.push_back(lit ? typed : predict_contact(kind, p));
        @(negedge i_clk);
    endtask

    // Mostly nearby pairs of a chosen scale, the rest fully random
    task automatic random_pair(output t_kind kind, output t_pair p);
        int pick;
        int span;
        int off_x;
        int off_y;
        pick = $urandom_range(9);
        if (pick <= 3)                kind = KIND_RECT;
        else if (pick <= 8)           kind = KIND_CIRCLE;
        else if ($urandom_range(1))   kind = KIND_OTHER;
        else                          kind = KIND_UNUSED;
        p = {$urandom, $urandom, $urandom, $urandom};
        p.pad = '0;
        if ($urandom_range(99) >= 20) begin
            pick  = $urandom_range(99);
            span  = (pick < 60) ? 64 : ((pick < 90) ? 1024 : 32767);
            p.a_w = SB'($urandom_range(span));
            p.a_h = SB'($urandom_range(span));
            p.b_w = SB'($urandom_range(span));
            p.b_h = SB'($urandom_range(span));
            off_x = int'($urandom_range(4 * span)) - 2 * span;
            off_y = int'($urandom_range(4 * span)) - 2 * span;
            p.b_x = CB'(int'(p.a_x) + off_x);
            p.b_y = CB'(int'(p.a_y) + off_y);
        end
    endtask

    // Receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_contact want;
        t_contact got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit  = m_axis_tuser;
            got.side = t_side'(m_axis_tdata[2:0]);
            got.cx   = m_axis_tdata[3 +: OB];
            got.cy   = m_axis_tdata[3 + OB +: OB];
            if (expected_contacts.size() == 0) begin
                $error("result with nothing expected: hit %0d side %0d", got.hit, got.side);
                fail_count++;
            end else begin
                want = expected_contacts.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    fail_count++;
                end
                if (got.side !== want.side) begin
                    $error("hit_side: expected %0d, got %0d", want.side, got.side);
                    fail_count++;
                end
                if (got.cx !== want.cx) begin
                    $error("contact_x: expected %0d, got %0d",
                           $signed(want.cx), $signed(got.cx));
                    fail_count++;
                end
                if (got.cy !== want.cy) begin
                    $error("contact_y: expected %0d, got %0d",
                           $signed(want.cy), $signed(got.cy));
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        t_pair    p;
        t_kind    kind;
        t_contact typed;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        for (int r = 0; r < ROWS; r++) begin
            p       = '0;
            p.a_x   = shape_table[r].ax[CB-1:0];
            p.a_y   = shape_table[r].ay[CB-1:0];
            p.a_w   = shape_table[r].aw[SB-1:0];
            p.a_h   = shape_table[r].ah[SB-1:0];
            p.b_x   = shape_table[r].bx[CB-1:0];
            p.b_y   = shape_table[r].by[CB-1:0];
            p.b_w   = shape_table[r].bw[SB-1:0];
            p.b_h   = shape_table[r].bh[SB-1:0];
            typed     = '0;
            typed.hit = shape_table[r].hit;
            offer_pair(shape_table[r].kind, p, shape_table[r].lit, typed);
        end

        // Random pairs in three phases of stall settings
        typed = '0;
        for (int i = 0; i < RAND_PAIRS; i++) begin
            if (i == RAND_PAIRS / 3) begin
                src_idle_pct = 70;
                snk_idle_pct = 7;
            end else if (i == 2 * RAND_PAIRS / 3) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            random_pair(kind, p);
            offer_pair(kind, p, 1'b0, typed);
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow for stray results
        while (expected_contacts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: circle_box_collision_test_unit.f
sv/cbct_pkg.sv
sv/cbct_setup.sv
sv/cbct_clamp.sv
sv/cbct_dist.sv
sv/cbct_square.sv
sv/circle_box_collision_test_unit.sv
test/circle_box_collision_test_unit_tb.sv
